@@ src/arm_pid_pkg.sv @@
// Shared types, codes and constants for the arm position PID block.
// Used by arm_pid_calc and arm_position_pid_with_stops; no dependencies.
package arm_pid_pkg;

    // Number of named target positions held in the packed table.
    localparam int NUM_TARGETS = 5;
    localparam int DEG_W       = 9;
    localparam int TABLE_W     = DEG_W * NUM_TARGETS;
    localparam int GAIN_W      = 16;
    localparam int CFG_DATA_W  = (TABLE_W > GAIN_W) ? TABLE_W : GAIN_W;
    localparam int CFG_IDX_W   = 3;

    localparam int ANGLE_W = 16;
    localparam int ERR_W   = ANGLE_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int ESUM_W  = 32;
    localparam int VEL_W   = 16;

    localparam int CDEG_PER_DEG    = 100;
    localparam int STOP_BAND_CDEG  = 200;
    localparam int HANG_LIMIT_CDEG = 30000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_TABLE = 3'd4;

    // Request codes.
    localparam logic [1:0] REQ_SAMPLE     = 2'd0;
    localparam logic [1:0] REQ_SET_TARGET = 2'd1;
    localparam logic [1:0] REQ_SET_ENABLE = 2'd2;

    // Target codes with a stop rule.
    localparam logic [2:0] TGT_REST    = 3'd0;
    localparam logic [2:0] TGT_LOADING = 3'd1;
    localparam logic [2:0] TGT_HANGING = 3'd4;

    // Brake actions.
    localparam logic [1:0] BRAKE_NONE  = 2'd0;
    localparam logic [1:0] BRAKE_HOLD  = 2'd1;
    localparam logic [1:0] BRAKE_COAST = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ANGLE_W-1:0] angle_cdeg;
        logic [2:0]         cmd_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic [1:0]              brake_action;
        logic                    loop_enabled;
        logic [2:0]              current_target;
    } t_out_beat;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [ANGLE_W-1:0]       err_limit;
    } t_gains;

    typedef struct packed {
        logic signed [ESUM_W-1:0] error_sum;
        logic signed [ERR_W-1:0]  prev_error;
    } t_pid_state;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic                    near_target;
        t_pid_state              next_state;
    } t_pid_result;

endpackage

@@ src/arm_pid_calc.sv @@
// Control law for one sample: error, P/I/D products, scaled and saturated command,
// and the next integrator state. Depends on arm_pid_pkg.
module arm_pid_calc (
    input  arm_pid_pkg::t_gains               i_gains,
    input  arm_pid_pkg::t_pid_state           i_state,
    input  logic [arm_pid_pkg::DEG_W-1:0]     i_target_deg,
    input  logic [arm_pid_pkg::ANGLE_W-1:0]   i_angle_cdeg,
    output arm_pid_pkg::t_pid_result          o_result
);
    import arm_pid_pkg::*;

    localparam int P_W   = GAIN_W + ERR_W;
    localparam int D_W   = GAIN_W + DIFF_W;
    localparam int I_W   = GAIN_W + ESUM_W;
    localparam int SUM_W = I_W + 1;
    localparam int Q_W   = SUM_W - 8;

    localparam logic signed [Q_W-1:0] VEL_MAX = Q_W'((1 << (VEL_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] VEL_MIN = -Q_W'(1 << (VEL_W - 1));
    localparam logic signed [ESUM_W:0] ESUM_MAX = {2'b00, {(ESUM_W-1){1'b1}}};
    localparam logic signed [ESUM_W:0] ESUM_MIN = {2'b11, {(ESUM_W-1){1'b0}}};

    logic [ANGLE_W-1:0]       tgt_cdeg;
    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         mag;
    logic                     windup;
    logic signed [DIFF_W-1:0] diff;
    logic signed [P_W-1:0]    p_prod;
    logic signed [D_W-1:0]    d_prod;
    logic signed [I_W-1:0]    i_prod;
    logic signed [SUM_W-1:0]  sum;
    logic signed [Q_W-1:0]    q;
    logic signed [ESUM_W:0]   esum_add;

    // target in centidegrees always fits the angle width (511 * 100 < 2^16)
    assign tgt_cdeg = ANGLE_W'({{(ANGLE_W-DEG_W){1'b0}}, i_target_deg} * ANGLE_W'(CDEG_PER_DEG));
    assign err      = $signed({1'b0, tgt_cdeg}) - $signed({1'b0, i_angle_cdeg});
    assign mag      = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign windup   = mag > {1'b0, i_gains.err_limit};
    assign diff     = $signed({err[ERR_W-1], err})
                    - $signed({i_state.prev_error[ERR_W-1], i_state.prev_error});

    assign p_prod = i_gains.gain_p * err;
    assign d_prod = i_gains.gain_d * diff;
    assign i_prod = i_gains.gain_i * i_state.error_sum;

    assign sum = SUM_W'(p_prod) + SUM_W'(d_prod) + (windup ? SUM_W'(i_prod) : '0);
    // floor division by 256
    assign q   = sum[SUM_W-1:8];

    assign esum_add = (ESUM_W+1)'(i_state.error_sum) + (ESUM_W+1)'(err);

    always_comb begin
        if (q > VEL_MAX) begin
            o_result.velocity = VEL_MAX[VEL_W-1:0];
        end else if (q < VEL_MIN) begin
            o_result.velocity = VEL_MIN[VEL_W-1:0];
        end else begin
            o_result.velocity = q[VEL_W-1:0];
        end

        if (!windup) begin
            o_result.next_state.error_sum = i_state.error_sum;
        end else if (esum_add > ESUM_MAX) begin
            o_result.next_state.error_sum = ESUM_MAX[ESUM_W-1:0];
        end else if (esum_add < ESUM_MIN) begin
            o_result.next_state.error_sum = ESUM_MIN[ESUM_W-1:0];
        end else begin
            o_result.next_state.error_sum = esum_add[ESUM_W-1:0];
        end

        o_result.next_state.prev_error = err;
        o_result.near_target = mag < ERR_W'(STOP_BAND_CDEG);
    end

endmodule

@@ src/arm_position_pid_with_stops.sv @@
// Top level of the arm position PID loop with target stop rules.
// Depends on arm_pid_pkg and arm_pid_calc.

// Position loop for a motor-driven arm. Requests arrive as input beats: a set-target
// beat picks one of the named positions from the packed position table and turns the
// loop on, a set-enable beat turns it on (nonzero) or off, and a sample beat carries
// the measured angle in centidegrees. Every sample taken while the loop is on gives
// one result beat with the saturated velocity command, a brake action and the loop
// state after the stop rules; all other beats give no result. Beats pass through an
// input register and a result register, and one beat per cycle is sustained while
// results are taken without stalling: the whole control law, three multipliers and
// their sum, sits between those two registers, and the integrator and previous error
// update at the same edge as the result register so the next sample sees them at
// once. A waiting result stalls the input register only when the result register is
// full and not being taken. Configuration writes take effect on the next edge and
// should be made while no beat is in flight.
module arm_position_pid_with_stops (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  arm_pid_pkg::t_in_beat                 i_in_beat,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output arm_pid_pkg::t_out_beat                o_out_beat,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [arm_pid_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [arm_pid_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import arm_pid_pkg::*;

    // configuration
    t_gains               r_gains;
    logic [TABLE_W-1:0]   r_table;

    // loop state
    logic [2:0]           r_target_code, n_target_code;
    logic [DEG_W-1:0]     r_target_deg,  n_target_deg;
    logic                 r_loop_on,     n_loop_on;
    t_pid_state           r_state,       n_state;

    // pipeline
    logic                 r_in_valid;
    t_in_beat             r_in;
    logic                 r_out_valid,   n_out_valid;
    t_out_beat            r_out_beat,    n_out_beat;

    logic                 advance;
    logic                 fire;
    logic                 produce;
    logic [DEG_W-1:0]     table_deg;
    t_pid_result          law;

    // result register free, or being emptied this cycle
    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_comb begin
        table_deg = '0;
        for (int k = 0; k < NUM_TARGETS; k++) begin
            if (r_in.cmd_value == 3'(k)) begin
                table_deg = r_table[k*DEG_W +: DEG_W];
            end
        end
    end

    arm_pid_calc u_calc (
        .i_gains      (r_gains),
        .i_state      (r_state),
        .i_target_deg (r_target_deg),
        .i_angle_cdeg (r_in.angle_cdeg),
        .o_result     (law)
    );

    always_comb begin
        n_target_code = r_target_code;
        n_target_deg  = r_target_deg;
        n_loop_on     = r_loop_on;
        n_state       = r_state;
        produce       = 1'b0;

        n_out_beat.velocity       = law.velocity;
        n_out_beat.brake_action   = BRAKE_NONE;
        n_out_beat.loop_enabled   = r_loop_on;
        n_out_beat.current_target = r_target_code;

        if (fire) begin
            case (r_in.req_type)
                REQ_SET_TARGET: begin
                    // codes past the table are dropped without touching state
                    if (r_in.cmd_value < 3'(NUM_TARGETS)) begin
                        n_target_code = r_in.cmd_value;
                        n_target_deg  = table_deg;
                        n_loop_on     = 1'b1;
                    end
                end
                REQ_SET_ENABLE: begin
                    n_loop_on = (r_in.cmd_value != '0);
                end
                REQ_SAMPLE: begin
                    if (r_loop_on) begin
                        produce = 1'b1;
                        n_state = law.next_state;
                        // stop rules run after the command; velocity still goes out
                        if (r_target_code == TGT_LOADING && law.near_target) begin
                            n_loop_on               = 1'b0;
                            n_out_beat.brake_action = BRAKE_HOLD;
                        end
                        if (r_target_code == TGT_REST && law.near_target) begin
                            n_loop_on               = 1'b0;
                            n_out_beat.brake_action = BRAKE_COAST;
                        end
                        if (r_target_code == TGT_HANGING
                                && r_in.angle_cdeg > ANGLE_W'(HANG_LIMIT_CDEG)) begin
                            n_loop_on               = 1'b0;
                            n_out_beat.brake_action = BRAKE_COAST;
                        end
                        n_out_beat.loop_enabled = n_loop_on;
                    end
                end
                default: begin
                    // unused request code: no effect
                end
            endcase
        end

        if (produce) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
            r_table <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P:    r_gains.gain_p    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    r_gains.gain_i    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    r_gains.gain_d    <= i_cfg_data[GAIN_W-1:0];
                CFG_ERR_LIMIT: r_gains.err_limit <= i_cfg_data[ANGLE_W-1:0];
                CFG_POS_TABLE: r_table           <= i_cfg_data[TABLE_W-1:0];
                default: begin
                    // index past the register list: ignored
                end
            endcase
        end
    end

    // control state and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_target_code <= TGT_REST;
            r_target_deg  <= '0;
            r_loop_on     <= 1'b0;
            r_state       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid   <= n_out_valid;
            r_target_code <= n_target_code;
            r_target_deg  <= n_target_deg;
            r_loop_on     <= n_loop_on;
            r_state       <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_beat;
        end
        if (produce) begin
            r_out_beat <= n_out_beat;
        end
    end

endmodule
